// ===== rtl/idq_pkg.sv =====
// Shared types, widths and register codes of the INT4 group dequant matvec block.
`timescale 1ns / 1ps
package idq_pkg;

  localparam int POS_W     = 12;
  localparam int IDX_W     = 12;
  localparam int ACT_W     = 16;
  localparam int COEF_W    = 16;
  localparam int NIB_W     = 4;
  localparam int WQ_W      = 21;
  localparam int PROD_W    = WQ_W + ACT_W;
  localparam int SUM_W     = 48;
  localparam int ROW_W     = 16;
  localparam int LEN_W     = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_ROW_LENGTH_DEF = 4096;
  localparam int ACC_WIDTH_DEF      = 48;

  localparam logic [LEN_W-1:0] ROW_LENGTH_RST   = LEN_W'(4096);
  localparam logic [LEN_W-1:0] GROUP_LENGTH_RST = LEN_W'(128);
  localparam logic [ROW_W-1:0] ROW_COUNT_RST    = ROW_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(2);

  localparam logic MODE_ACT    = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_MUL,
    ST_ADD_HI,
    ST_ADD_LO
  } state_e;

  typedef struct packed {
    logic deq;
    logic mul;
  } lane_ctl_t;

  typedef struct packed {
    logic add_hi;
    logic add_lo;
    logic clear;
  } merge_ctl_t;

endpackage

// ===== rtl/idq_act_store.sv =====
// Activation store: even and odd column banks, one registered read port each.
`timescale 1ns / 1ps
module idq_act_store #(
  parameter int MAX_ROW_LENGTH = idq_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic        [idq_pkg::IDX_W-1:0]    wr_idx_i,
  input  logic signed [idq_pkg::ACT_W-1:0]    wr_data_i,
  input  logic                                rd_en_i,
  input  logic        [idq_pkg::POS_W-1:0]    rd_pos_i,
  output logic signed [idq_pkg::ACT_W-1:0]    rd_even_o,
  output logic signed [idq_pkg::ACT_W-1:0]    rd_odd_o
);
  import idq_pkg::*;

  localparam int BANK_D  = (MAX_ROW_LENGTH + 1) / 2;
  localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  logic signed [ACT_W-1:0] even_mem [BANK_D];
  logic signed [ACT_W-1:0] odd_mem  [BANK_D];
  logic                    wr_ok;
  logic [BANK_AW-1:0]      wr_addr;
  logic [BANK_AW-1:0]      rd_addr;

  assign wr_ok   = wr_en_i && (int'(wr_idx_i) < MAX_ROW_LENGTH);
  assign wr_addr = BANK_AW'(wr_idx_i >> 1);
  assign rd_addr = BANK_AW'(rd_pos_i);

  always_ff @(posedge clk_i) begin
    if (wr_ok && !wr_idx_i[0]) begin
      even_mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_even_o <= even_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok && wr_idx_i[0]) begin
      odd_mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_odd_o <= odd_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/idq_lane.sv =====
// One nibble lane: dequantize the weight, then multiply it with its activation.
`timescale 1ns / 1ps
module idq_lane (
  input  logic                                clk_i,
  input  idq_pkg::lane_ctl_t                  ctl_i,
  input  logic        [idq_pkg::NIB_W-1:0]    nibble_i,
  input  logic signed [idq_pkg::COEF_W-1:0]   scale_i,
  input  logic signed [idq_pkg::COEF_W-1:0]   offset_i,
  input  logic signed [idq_pkg::ACT_W-1:0]    act_i,
  output logic signed [idq_pkg::PROD_W-1:0]   prod_o
);
  import idq_pkg::*;

  logic signed [NIB_W:0]    nib_s;
  logic signed [WQ_W-1:0]   w_d, w_q;
  logic signed [ACT_W-1:0]  act_q;
  logic signed [PROD_W-1:0] prod_d;

  assign nib_s  = {1'b0, nibble_i};
  assign w_d    = WQ_W'(nib_s) * WQ_W'(scale_i) + WQ_W'(offset_i);
  assign prod_d = PROD_W'(w_q) * PROD_W'(act_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.deq) begin
      w_q   <= w_d;
      act_q <= act_i;
    end
    if (ctl_i.mul) begin
      prod_o <= prod_d;
    end
  end

endmodule

// ===== rtl/idq_merge.sv =====
// Merge stage: saturating accumulate of the high then low lane product.
`timescale 1ns / 1ps
module idq_merge #(
  parameter int ACC_WIDTH = idq_pkg::ACC_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  idq_pkg::merge_ctl_t                 ctl_i,
  input  logic signed [idq_pkg::PROD_W-1:0]   prod_hi_i,
  input  logic signed [idq_pkg::PROD_W-1:0]   prod_lo_i,
  output logic signed [idq_pkg::SUM_W-1:0]    sum_o
);
  import idq_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic signed [ACC_WIDTH:0]   sum_hi, sum_lo;
  logic signed [ACC_WIDTH-1:0] sat_hi, sat_lo;

  always_comb begin
    sum_hi = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(prod_hi_i);
    if (sum_hi[ACC_WIDTH] != sum_hi[ACC_WIDTH-1]) begin
      sat_hi = sum_hi[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_hi = sum_hi[ACC_WIDTH-1:0];
    end
    sum_lo = (ACC_WIDTH+1)'(acc_q) + (ACC_WIDTH+1)'(prod_lo_i);
    if (sum_lo[ACC_WIDTH] != sum_lo[ACC_WIDTH-1]) begin
      sat_lo = sum_lo[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_lo = sum_lo[ACC_WIDTH-1:0];
    end
  end

  generate
    if (ACC_WIDTH > SUM_W) begin : g_clamp
      logic [ACC_WIDTH-SUM_W:0] top_bits;
      assign top_bits = sat_lo[ACC_WIDTH-1:SUM_W-1];
      always_comb begin
        if (top_bits == '0 || top_bits == '1) begin
          sum_o = sat_lo[SUM_W-1:0];
        end else if (sat_lo[ACC_WIDTH-1]) begin
          sum_o = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
          sum_o = {1'b0, {(SUM_W-1){1'b1}}};
        end
      end
    end else begin : g_extend
      assign sum_o = SUM_W'(sat_lo);
    end
  endgenerate

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.add_hi) begin
      acc_d = sat_hi;
    end else if (ctl_i.add_lo) begin
      acc_d = ctl_i.clear ? '0 : sat_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== rtl/int4_group_dequant_matvec_top.sv =====
// Top level of the INT4 group dequant matvec block: control, config and output register.
`timescale 1ns / 1ps
// Mode 0 items write one activation into the store. Mode 1 items carry one weight
// byte: the accept cycle reads both activations from the two store banks, then the
// two nibble lanes dequantize, then they multiply, then the merge stage adds the
// high-lane and then the low-lane product into the accumulator, one add after the
// other because each saturates. The next item is accepted once the low add is done;
// a row sum waits in the output register while further items proceed, and only a
// second row end blocks in the last add until the earlier sum is transferred.
// The activation store has no reset; reading an entry never written gives an
// undefined sum.
module int4_group_dequant_matvec_top #(
  parameter int MAX_ROW_LENGTH = idq_pkg::MAX_ROW_LENGTH_DEF,
  parameter int ACC_WIDTH      = idq_pkg::ACC_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [idq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [idq_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  mode_i,
  input  logic        [idq_pkg::IDX_W-1:0]      act_index_i,
  input  logic signed [idq_pkg::ACT_W-1:0]      act_value_i,
  input  logic        [7:0]                     weight_byte_i,
  input  logic signed [idq_pkg::COEF_W-1:0]     group_scale_i,
  input  logic signed [idq_pkg::COEF_W-1:0]     group_offset_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [idq_pkg::SUM_W-1:0]      row_sum_o,
  output logic        [idq_pkg::ROW_W-1:0]      row_number_o,
  output logic                                  last_row_o
);
  import idq_pkg::*;

  localparam int ROW_BYTES_MAX = (MAX_ROW_LENGTH / 2 > 0) ? MAX_ROW_LENGTH / 2 : 1;

  state_e state_q, state_d;

  logic [LEN_W-1:0] row_length_q, group_length_q;
  logic [ROW_W-1:0] row_count_q;

  logic [POS_W-1:0]         byte_pos_q, group_pos_q;
  logic [ROW_W-1:0]         row_counter_q;
  logic signed [COEF_W-1:0] held_scale_q, held_offset_q;
  logic [7:0]               byte_q;
  logic                     row_end_q;
  logic [ROW_W-1:0]         item_row_q;
  logic                     item_last_q;

  logic                     out_valid_q;
  logic signed [SUM_W-1:0]  row_sum_q;
  logic [ROW_W-1:0]         row_number_q;
  logic                     last_row_q;

  logic                     accept, accept_w, accept_a;
  logic [POS_W-1:0]         rl_half, row_bytes, gl_half, group_bytes;
  logic [POS_W:0]           bp_inc, gp_inc;
  logic                     row_end, row_last;
  logic [ROW_W-1:0]         row_inc;
  logic                     out_free, out_load;
  lane_ctl_t                lane_ctl;
  merge_ctl_t               merge_ctl;

  logic signed [ACT_W-1:0]  act_even, act_odd;
  logic signed [PROD_W-1:0] prod_hi, prod_lo;
  logic signed [SUM_W-1:0]  merged_sum;

  assign accept   = in_valid_i && !in_stall_o;
  assign accept_w = accept && (mode_i == MODE_WEIGHT);
  assign accept_a = accept && (mode_i == MODE_ACT);

  always_comb begin
    rl_half = row_length_q[LEN_W-1:1];
    if (int'(rl_half) > ROW_BYTES_MAX) begin
      row_bytes = POS_W'(ROW_BYTES_MAX);
    end else if (rl_half == '0) begin
      row_bytes = POS_W'(1);
    end else begin
      row_bytes = rl_half;
    end
    gl_half     = group_length_q[LEN_W-1:1];
    group_bytes = (gl_half == '0) ? POS_W'(1) : gl_half;
    bp_inc      = {1'b0, byte_pos_q} + (POS_W+1)'(1);
    gp_inc      = {1'b0, group_pos_q} + (POS_W+1)'(1);
    row_end     = bp_inc >= {1'b0, row_bytes};
    row_inc     = row_counter_q + ROW_W'(1);
    row_last    = row_inc == row_count_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept_w) state_d = ST_DEQ;
      ST_DEQ:    state_d = ST_MUL;
      ST_MUL:    state_d = ST_ADD_HI;
      ST_ADD_HI: state_d = ST_ADD_LO;
      ST_ADD_LO: if (!row_end_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    lane_ctl         = '0;
    merge_ctl        = '0;
    merge_ctl.clear  = row_end_q;
    out_load         = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_DEQ:    lane_ctl.deq = 1'b1;
      ST_MUL:    lane_ctl.mul = 1'b1;
      ST_ADD_HI: merge_ctl.add_hi = 1'b1;
      ST_ADD_LO: begin
        merge_ctl.add_lo = !row_end_q || out_free;
        out_load         = row_end_q && out_free;
      end
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      row_length_q   <= ROW_LENGTH_RST;
      group_length_q <= GROUP_LENGTH_RST;
      row_count_q    <= ROW_COUNT_RST;
      byte_pos_q     <= '0;
      group_pos_q    <= '0;
      row_counter_q  <= '0;
      held_scale_q   <= '0;
      held_offset_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ROW_LENGTH:   row_length_q   <= cfg_data_i[LEN_W-1:0];
          REG_GROUP_LENGTH: group_length_q <= cfg_data_i[LEN_W-1:0];
          REG_ROW_COUNT:    row_count_q    <= cfg_data_i[ROW_W-1:0];
          default:          row_count_q    <= row_count_q;
        endcase
      end
      if (accept_w) begin
        if (group_pos_q == '0) begin
          held_scale_q  <= group_scale_i;
          held_offset_q <= group_offset_i;
        end
        if (row_end) begin
          byte_pos_q    <= '0;
          group_pos_q   <= '0;
          row_counter_q <= row_last ? '0 : row_inc;
        end else begin
          byte_pos_q  <= bp_inc[POS_W-1:0];
          group_pos_q <= (gp_inc >= {1'b0, group_bytes}) ? '0 : gp_inc[POS_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      byte_q      <= weight_byte_i;
      row_end_q   <= row_end;
      item_row_q  <= row_counter_q;
      item_last_q <= row_last;
    end
    if (out_load) begin
      row_sum_q    <= merged_sum;
      row_number_q <= item_row_q;
      last_row_q   <= item_last_q;
    end
  end

  idq_act_store #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept_a),
    .wr_idx_i  (act_index_i),
    .wr_data_i (act_value_i),
    .rd_en_i   (accept_w),
    .rd_pos_i  (byte_pos_q),
    .rd_even_o (act_even),
    .rd_odd_o  (act_odd)
  );

  idq_lane u_lane_hi (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .nibble_i (byte_q[7:4]),
    .scale_i  (held_scale_q),
    .offset_i (held_offset_q),
    .act_i    (act_even),
    .prod_o   (prod_hi)
  );

  idq_lane u_lane_lo (
    .clk_i    (clk_i),
    .ctl_i    (lane_ctl),
    .nibble_i (byte_q[3:0]),
    .scale_i  (held_scale_q),
    .offset_i (held_offset_q),
    .act_i    (act_odd),
    .prod_o   (prod_lo)
  );

  idq_merge #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (merge_ctl),
    .prod_hi_i (prod_hi),
    .prod_lo_i (prod_lo),
    .sum_o     (merged_sum)
  );

  assign out_valid_o  = out_valid_q;
  assign row_sum_o    = row_sum_q;
  assign row_number_o = row_number_q;
  assign last_row_o   = last_row_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the INT4 group dequant matvec block with its own row-sum predictor.
`timescale 1ns / 1ps
module tb_top;
  import idq_pkg::*;

  localparam int STORE_DEPTH     = MAX_ROW_LENGTH_DEF;
  localparam int ACC_BITS        = ACC_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 7;
  localparam int PHASE_ITEMS     = 140;
  localparam int ACT_FILL        = 256;
  localparam int RESET_ROW_BYTES = 70;

  localparam logic signed [ACT_W-1:0] Q12_MIN = 16'sh8000;
  localparam logic signed [ACT_W-1:0] Q12_MAX = 16'sh7FFF;

  typedef struct {
    logic                     mode;
    logic [IDX_W-1:0]         act_index;
    logic signed [ACT_W-1:0]  act_value;
    logic [7:0]               weight_byte;
    logic signed [COEF_W-1:0] group_scale;
    logic signed [COEF_W-1:0] group_offset;
  } mv_item_t;

  typedef struct {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_number;
    logic                    last_row;
  } row_result_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i    = REG_ROW_LENGTH;
  logic [CFG_W-1:0]         cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic                     mode_i         = MODE_ACT;
  logic [IDX_W-1:0]         act_index_i    = '0;
  logic signed [ACT_W-1:0]  act_value_i    = '0;
  logic [7:0]               weight_byte_i  = '0;
  logic signed [COEF_W-1:0] group_scale_i  = '0;
  logic signed [COEF_W-1:0] group_offset_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic signed [SUM_W-1:0]  row_sum_o;
  logic [ROW_W-1:0]         row_number_o;
  logic                     last_row_o;

  int4_group_dequant_matvec_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [LEN_W-1:0]        cfg_row_length   = ROW_LENGTH_RST;
  logic [LEN_W-1:0]        cfg_group_length = GROUP_LENGTH_RST;
  logic [ROW_W-1:0]        cfg_row_count    = ROW_COUNT_RST;
  logic signed [ACT_W-1:0] act_mem [STORE_DEPTH];
  longint                  acc_q            = 0;
  int unsigned             byte_pos         = 0;
  int unsigned             grp_pos          = 0;
  longint                  held_scale       = 0;
  longint                  held_offset      = 0;
  logic [ROW_W-1:0]        row_ctr          = '0;
  row_result_t             pending_sums [$];

  int unsigned n_in           = 0;
  int unsigned n_sums         = 0;
  int unsigned n_fail         = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;
  int unsigned stuck_cycles   = 0;
  bit          gaps_on        = 1'b0;
  bit          stalls_on      = 1'b0;

  function automatic longint acc_saturate(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic dequant_accumulate(input mv_item_t it);
    int unsigned      row_bytes;
    int unsigned      grp_bytes;
    int unsigned      col;
    longint           w_hi;
    longint           w_lo;
    logic [ROW_W-1:0] next_row;
    row_result_t      r;
    if (it.mode == MODE_ACT) begin
      act_mem[it.act_index] = it.act_value;
    end else begin
      row_bytes = cfg_row_length >> 1;
      if (row_bytes > STORE_DEPTH / 2) row_bytes = STORE_DEPTH / 2;
      if (row_bytes == 0) row_bytes = 1;
      grp_bytes = cfg_group_length >> 1;
      if (grp_bytes == 0) grp_bytes = 1;
      if (grp_pos == 0) begin
        held_scale  = it.group_scale;
        held_offset = it.group_offset;
      end
      w_hi = longint'(it.weight_byte[7:4]) * held_scale + held_offset;
      w_lo = longint'(it.weight_byte[3:0]) * held_scale + held_offset;
      col = byte_pos * 2;
      acc_q = acc_saturate(acc_q + w_hi * longint'(act_mem[col]));
      acc_q = acc_saturate(acc_q + w_lo * longint'(act_mem[col + 1]));
      grp_pos++;
      if (grp_pos >= grp_bytes) grp_pos = 0;
      byte_pos++;
      if (byte_pos >= row_bytes) begin
        next_row     = row_ctr + 1'b1;
        r.row_sum    = acc_q[SUM_W-1:0];
        r.row_number = row_ctr;
        r.last_row   = (next_row == cfg_row_count);
        row_ctr      = r.last_row ? '0 : next_row;
        pending_sums.push_back(r);
        acc_q    = 0;
        byte_pos = 0;
        grp_pos  = 0;
      end
    end
  endtask

  function automatic logic signed [ACT_W-1:0] rand_q12();
    case ($urandom_range(0, 9))
      0: return Q12_MIN;
      1: return Q12_MAX;
      default: return ACT_W'($urandom);
    endcase
  endfunction

  function automatic mv_item_t act_item(input logic [IDX_W-1:0] idx,
                                        input logic signed [ACT_W-1:0] val);
    mv_item_t it;
    it.mode         = MODE_ACT;
    it.act_index    = idx;
    it.act_value    = val;
    it.weight_byte  = 8'($urandom);
    it.group_scale  = COEF_W'($urandom);
    it.group_offset = COEF_W'($urandom);
    return it;
  endfunction

  function automatic mv_item_t weight_item(input logic [7:0] wb,
                                           input logic signed [COEF_W-1:0] sc,
                                           input logic signed [COEF_W-1:0] ofs);
    mv_item_t it;
    it.mode         = MODE_WEIGHT;
    it.act_index    = IDX_W'($urandom);
    it.act_value    = ACT_W'($urandom);
    it.weight_byte  = wb;
    it.group_scale  = sc;
    it.group_offset = ofs;
    return it;
  endfunction

  function automatic mv_item_t random_weight();
    return weight_item(8'($urandom), rand_q12(), rand_q12());
  endfunction

  task automatic send_item(input mv_item_t it);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    mode_i         <= it.mode;
    act_index_i    <= it.act_index;
    act_value_i    <= it.act_value;
    weight_byte_i  <= it.weight_byte;
    group_scale_i  <= it.group_scale;
    group_offset_i <= it.group_offset;
    do @(posedge clk_i); while (in_stall_o);
    n_in++;
    dequant_accumulate(it);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    @(posedge clk_i);
    case (idx)
      REG_ROW_LENGTH:   cfg_row_length = LEN_W'(value);
      REG_GROUP_LENGTH: cfg_group_length = LEN_W'(value);
      REG_ROW_COUNT:    cfg_row_count = ROW_W'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int unsigned row_len, input int unsigned grp_len,
                           input int unsigned rows);
    write_reg(REG_ROW_LENGTH, row_len);
    write_reg(REG_GROUP_LENGTH, grp_len);
    write_reg(REG_ROW_COUNT, rows);
  endtask

  // drop valid, wait for every row sum, then let in-flight bytes finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_lengths();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < ACT_FILL; i++) send_item(act_item(IDX_W'(i), rand_q12()));
    repeat (RESET_ROW_BYTES) send_item(random_weight());
    settle();
    write_reg(REG_ROW_LENGTH, 16);
    send_item(random_weight());
    settle();
  endtask

  task automatic test_field_extremes();
    configure(4, 2, 3);
    send_item(act_item(IDX_W'(0), Q12_MIN));
    send_item(act_item(IDX_W'(1), Q12_MAX));
    send_item(act_item(IDX_W'(2), Q12_MIN));
    send_item(act_item(IDX_W'(3), Q12_MAX));
    send_item(weight_item(8'hFF, Q12_MIN, Q12_MIN));
    send_item(weight_item(8'h00, Q12_MAX, Q12_MAX));
    send_item(weight_item(8'hF0, Q12_MIN, Q12_MAX));
    send_item(weight_item(8'h0F, Q12_MAX, Q12_MIN));
    send_item(weight_item(8'hA5, 16'sd1, -16'sd1));
    send_item(weight_item(8'h5A, -16'sd1, 16'sd0));
    settle();
  endtask

  task automatic test_odd_lengths();
    configure(3, 1, 2);
    repeat (3) send_item(random_weight());
    settle();
    configure(0, 0, 1);
    repeat (2) send_item(random_weight());
    settle();
    configure(8191, 8191, 1);
    repeat (3) send_item(random_weight());
    settle();
    write_reg(REG_ROW_LENGTH, 2);
    send_item(random_weight());
    settle();
  endtask

  task automatic test_uneven_groups();
    configure(10, 4, 2);
    repeat (10) send_item(random_weight());
    settle();
    configure(12, 8, 2);
    repeat (12) send_item(random_weight());
    settle();
  endtask

  task automatic test_midrow_length_change();
    configure(16, 4, 4);
    repeat (5) send_item(random_weight());
    settle();
    write_reg(REG_ROW_LENGTH, 6);
    repeat (4) send_item(random_weight());
    repeat (2) send_item(random_weight());
    settle();
    write_reg(REG_ROW_LENGTH, 12);
    repeat (4) send_item(random_weight());
    repeat (3) send_item(random_weight());
    settle();
    write_reg(REG_GROUP_LENGTH, 2);
    repeat (3) send_item(random_weight());
    settle();
  endtask

  task automatic test_act_write_in_row();
    configure(8, 8, 2);
    repeat (2) send_item(random_weight());
    send_item(act_item(IDX_W'(5), rand_q12()));
    send_item(act_item(IDX_W'(6), rand_q12()));
    send_item(random_weight());
    send_item(act_item(IDX_W'(1), rand_q12()));
    send_item(random_weight());
    repeat (4) send_item(random_weight());
    settle();
  endtask

  task automatic test_row_count_zero();
    configure(2, 2, 0);
    repeat (5) send_item(random_weight());
    settle();
    write_reg(REG_ROW_COUNT, int'(row_ctr) + 3);
    repeat (3) send_item(random_weight());
    settle();
    configure(2, 2, 65535);
    repeat (4) send_item(random_weight());
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned len;
    int unsigned grp;
    int unsigned rows;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: len = 2 * $urandom_range(1, 16);
        3:       len = $urandom_range(0, 64);
        4:       len = $urandom_range(64, ACT_FILL);
        default: len = 2;
      endcase
      case ($urandom_range(0, 3))
        0:       grp = len;
        1:       grp = 2;
        default: grp = $urandom_range(0, len + 4);
      endcase
      rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 6);
      configure(len, grp, rows);
      gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 15) send_item(act_item(IDX_W'($urandom), rand_q12()));
        else send_item(random_weight());
      end
      settle();
    end
  endtask

  always @(negedge clk_i) begin
    if (!stalls_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left == 0) begin
      out_stall_i <= !out_stall_i;
      stall_left = out_stall_i ? $urandom_range(1, 10) : $urandom_range(1, 6);
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk_i) begin
    row_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_sums++;
      if (pending_sums.size() == 0) begin
        $error("row_sum: no result expected, got %0d for row %0d", row_sum_o, row_number_o);
        n_fail++;
      end else begin
        exp_r = pending_sums.pop_front();
        if (row_sum_o !== exp_r.row_sum) begin
          $error("row_sum: expected %0d, got %0d", exp_r.row_sum, row_sum_o);
          n_fail++;
        end
        if (row_number_o !== exp_r.row_number) begin
          $error("row_number: expected %0d, got %0d", exp_r.row_number, row_number_o);
          n_fail++;
        end
        if (last_row_o !== exp_r.last_row) begin
          $error("last_row: expected %0d, got %0d", exp_r.last_row, last_row_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding",
               stuck_cycles, pending_sums.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_lengths();
    test_field_extremes();
    test_odd_lengths();
    test_uneven_groups();
    test_midrow_length_change();
    test_act_write_in_row();
    test_row_count_zero();
    test_random_traffic();
    settle();
    $display("Transferred %0d input items and checked %0d row sums", n_in, n_sums);
    $display("Reset lengths, field extremes, odd and uneven lengths, mid-row changes, %s",
             "row count zero and random traffic were exercised");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
